// ===== rtl/core/utf8pc_pkg.sv =====
// Shared types, codes and helpers of the UTF-8 page cutter.
`default_nettype none

package utf8pc_pkg;

  // Largest page any request may ask for, whatever the page limit register holds.
  localparam logic [20:0] MAX_PAGE = 21'd65536;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Configuration register indexes.
  localparam logic REG_PAGE_BYTE_LIMIT     = 1'b0;
  localparam logic REG_SESSION_BYTE_BUDGET = 1'b1;

  localparam logic [16:0] PAGE_BYTE_LIMIT_RESET     = 17'd4096;
  localparam logic [47:0] SESSION_BYTE_BUDGET_RESET = 48'd1048576;

  // Result status codes.
  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_LIMIT   = 3'd1;
  localparam logic [2:0] STATUS_CURSOR  = 3'd2;
  localparam logic [2:0] STATUS_INVALID = 3'd3;
  localparam logic [2:0] STATUS_BUDGET  = 3'd4;

  // Item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [19:0] request_limit;
    logic [47:0] bytes_remaining;
    logic [7:0]  data_byte;
    logic        window_end;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] page_bytes;
    logic        end_of_resource;
    logic [47:0] total_delivered;
  } res_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic        kind;
    logic        limit_bad;
    logic        rem_zero;
    logic [19:0] request_limit;
    logic [47:0] bytes_remaining;
    logic [7:0]  data_byte;
    logic        window_end;
    logic [2:0]  seq_n;
    logic        is_cont;
    logic        lt_a0;
    logic        lt_90;
    logic        gt_8f;
  } entry_t;

  // Length of the sequence that a lead byte opens; zero for a byte that cannot lead.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    if (b <= 8'h7F) begin
      n = 3'd1;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      n = 3'd2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      n = 3'd3;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      n = 3'd4;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utf8pc_front.sv =====
// Front end: classifies each incoming item before it enters the queue.
`default_nettype none

module utf8pc_front (
  input  utf8pc_pkg::req_t   req,
  input  logic [16:0]        page_byte_limit,
  output utf8pc_pkg::entry_t entry
);
  import utf8pc_pkg::*;

  always_comb begin
    entry.kind            = req.kind;
    entry.request_limit   = req.request_limit;
    entry.bytes_remaining = req.bytes_remaining;
    entry.data_byte       = req.data_byte;
    entry.window_end      = req.window_end;
    entry.limit_bad       = (req.request_limit == 20'd0) ||
                            (req.request_limit > {3'd0, page_byte_limit}) ||
                            ({1'b0, req.request_limit} > MAX_PAGE);
    entry.rem_zero        = (req.bytes_remaining == 48'd0);
    entry.seq_n           = seq_len(req.data_byte);
    entry.is_cont         = (req.data_byte & 8'hC0) == 8'h80;
    // Range flags for the second byte after the lead bytes with narrowed ranges.
    entry.lt_a0           = req.data_byte < 8'hA0;
    entry.lt_90           = req.data_byte < 8'h90;
    entry.gt_8f           = req.data_byte > 8'h8F;
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8pc_queue.sv =====
// Short queue of classified items between the front and the back.
`default_nettype none

module utf8pc_queue #(
  parameter int DEPTH = utf8pc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  utf8pc_pkg::entry_t push_data,
  output logic               full,
  input  logic               pop,
  output utf8pc_pkg::entry_t pop_data,
  output logic               empty
);
  import utf8pc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8pc_back.sv =====
// Back end: page state, UTF-8 checks, budget accounting and the result register.
`default_nettype none

module utf8pc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               entry_valid,
  input  utf8pc_pkg::entry_t entry,
  output logic               entry_take,
  input  logic [47:0]        session_byte_budget,
  output logic               res_valid,
  input  logic               res_stall,
  output utf8pc_pkg::res_t   res
);
  import utf8pc_pkg::*;

  logic [47:0] delivered_total, delivered_total_next;
  logic [19:0] active_limit, active_limit_next;
  logic [47:0] left_in_resource, left_in_resource_next;
  logic [19:0] byte_position, byte_position_next;
  logic [19:0] committed_size, committed_size_next;
  logic [1:0]  pending, pending_next;
  logic [7:0]  lead_byte, lead_byte_next;
  logic        straddling, straddling_next;
  logic        page_decided, page_decided_next;
  logic [2:0]  fault_code, fault_code_next;
  // Budget minus delivered; the top bit set means the budget is already overrun.
  logic [48:0] headroom;

  logic        emit;
  logic [2:0]  st;
  logic [19:0] pg;
  logic        eor;
  logic        bad;
  logic [19:0] pos_inc;
  logic [2:0]  lead_len;
  logic [2:0]  more;

  assign entry_take = entry_valid && (!res_valid || !res_stall);
  assign pos_inc    = byte_position + 20'd1;
  assign lead_len   = seq_len(lead_byte);
  assign more       = entry.seq_n - 3'd1;

  always_comb begin
    delivered_total_next  = delivered_total;
    active_limit_next     = active_limit;
    left_in_resource_next = left_in_resource;
    byte_position_next    = byte_position;
    committed_size_next   = committed_size;
    pending_next          = pending;
    lead_byte_next        = lead_byte;
    straddling_next       = straddling;
    page_decided_next     = page_decided;
    fault_code_next       = fault_code;
    emit                  = 1'b0;
    st                    = STATUS_OK;
    pg                    = 20'd0;
    eor                   = 1'b0;
    bad                   = 1'b0;
    if (entry_take) begin
      if (entry.kind == KIND_START) begin
        active_limit_next     = 20'd0;
        left_in_resource_next = 48'd0;
        byte_position_next    = 20'd0;
        committed_size_next   = 20'd0;
        pending_next          = 2'd0;
        lead_byte_next        = 8'd0;
        straddling_next       = 1'b0;
        page_decided_next     = 1'b0;
        fault_code_next       = STATUS_OK;
        if (entry.limit_bad) begin
          emit = 1'b1;
          st   = STATUS_LIMIT;
        end else if (entry.rem_zero) begin
          emit = 1'b1;
          eor  = 1'b1;
        end else begin
          active_limit_next     = entry.request_limit;
          left_in_resource_next = entry.bytes_remaining;
        end
      end else if (active_limit != 20'd0) begin
        if (fault_code == STATUS_OK && !page_decided) begin
          if (pending == 2'd0) begin
            if (byte_position >= active_limit) begin
              page_decided_next = 1'b1;
            end else if (byte_position == 20'd0 && entry.is_cont) begin
              fault_code_next = STATUS_CURSOR;
            end else if (entry.seq_n == 3'd0) begin
              fault_code_next = STATUS_INVALID;
            end else if (entry.seq_n == 3'd1) begin
              committed_size_next = pos_inc;
            end else begin
              pending_next    = more[1:0];
              lead_byte_next  = entry.data_byte;
              straddling_next = ({1'b0, byte_position} + {18'd0, entry.seq_n}) >
                                {1'b0, active_limit};
            end
          end else begin
            bad = !entry.is_cont;
            // The first continuation after some lead bytes has a narrower range.
            if (({1'b0, pending} + 3'd1) == lead_len) begin
              if (lead_byte == 8'hE0 && entry.lt_a0) bad = 1'b1;
              if (lead_byte == 8'hED && !entry.lt_a0) bad = 1'b1;
              if (lead_byte == 8'hF0 && entry.lt_90) bad = 1'b1;
              if (lead_byte == 8'hF4 && entry.gt_8f) bad = 1'b1;
            end
            if (bad) begin
              fault_code_next = STATUS_INVALID;
            end else begin
              pending_next = pending - 2'd1;
              if (pending == 2'd1) begin
                if (straddling) begin
                  page_decided_next = 1'b1;
                end else begin
                  committed_size_next = pos_inc;
                end
              end
            end
          end
          if (byte_position != 20'hFFFFF) begin
            byte_position_next = pos_inc;
          end
        end
        if (entry.window_end) begin
          emit = 1'b1;
          st   = fault_code_next;
          if (st == STATUS_OK && pending_next != 2'd0 && !page_decided_next) begin
            st = STATUS_INVALID;
          end
          if (st == STATUS_OK && committed_size_next == 20'd0) begin
            st = STATUS_LIMIT;
          end
          if (st == STATUS_OK &&
              (headroom[48] || ({28'd0, committed_size_next} > headroom[47:0]))) begin
            st = STATUS_BUDGET;
          end
          if (st == STATUS_OK) begin
            delivered_total_next = delivered_total + {28'd0, committed_size_next};
            pg                   = committed_size_next;
            eor                  = ({28'd0, committed_size_next} == left_in_resource);
          end
          active_limit_next     = 20'd0;
          left_in_resource_next = 48'd0;
          byte_position_next    = 20'd0;
          committed_size_next   = 20'd0;
          pending_next          = 2'd0;
          lead_byte_next        = 8'd0;
          straddling_next       = 1'b0;
          page_decided_next     = 1'b0;
          fault_code_next       = STATUS_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delivered_total  <= 48'd0;
      active_limit     <= 20'd0;
      left_in_resource <= 48'd0;
      byte_position    <= 20'd0;
      committed_size   <= 20'd0;
      pending          <= 2'd0;
      lead_byte        <= 8'd0;
      straddling       <= 1'b0;
      page_decided     <= 1'b0;
      fault_code       <= STATUS_OK;
      headroom         <= {1'b0, SESSION_BYTE_BUDGET_RESET};
      res_valid        <= 1'b0;
    end else begin
      delivered_total  <= delivered_total_next;
      active_limit     <= active_limit_next;
      left_in_resource <= left_in_resource_next;
      byte_position    <= byte_position_next;
      committed_size   <= committed_size_next;
      pending          <= pending_next;
      lead_byte        <= lead_byte_next;
      straddling       <= straddling_next;
      page_decided     <= page_decided_next;
      fault_code       <= fault_code_next;
      // A start item always separates two budget checks, so registering the headroom is safe.
      headroom         <= {1'b0, session_byte_budget} - {1'b0, delivered_total};
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.status          <= st;
      res.page_bytes      <= pg[16:0];
      res.end_of_resource <= eor;
      res.total_delivered <= delivered_total_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_page_cutter.sv =====
// Top level of the strict UTF-8 page cutter with session byte budget.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req (req_t)
//   res      out        res_valid / res_stall  res (res_t)
//   cfg      in         cfg_write              cfg_index, cfg_data
//
// One item is taken per cycle while the queue is not full. Each item is written into the queue;
// the back end takes it from the queue when no result is held, and its state update registers
// any result that the item causes in the result register.
// Synchronous reset clears the queue, the page state, the delivered total and the
// result valid flag, and loads the register reset values.
// A held result stalls the back end; the queue of QUEUE_DEPTH items then fills and
// req_stall rises only when it is full.
`default_nettype none

module utf8_page_cutter #(
  parameter int QUEUE_DEPTH = utf8pc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  utf8pc_pkg::req_t req,
  output logic             res_valid,
  input  logic             res_stall,
  output utf8pc_pkg::res_t res,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [47:0]      cfg_data
);
  import utf8pc_pkg::*;

  logic [16:0] page_byte_limit;
  logic [47:0] session_byte_budget;
  entry_t      front_entry;
  entry_t      queue_entry;
  logic        queue_full;
  logic        queue_empty;
  logic        queue_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_byte_limit     <= PAGE_BYTE_LIMIT_RESET;
      session_byte_budget <= SESSION_BYTE_BUDGET_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PAGE_BYTE_LIMIT: page_byte_limit <= cfg_data[16:0];
        REG_SESSION_BYTE_BUDGET: session_byte_budget <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req_stall = queue_full;

  utf8pc_front u_front (
    .req             (req),
    .page_byte_limit (page_byte_limit),
    .entry           (front_entry)
  );

  utf8pc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid && !queue_full),
    .push_data (front_entry),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_data  (queue_entry),
    .empty     (queue_empty)
  );

  utf8pc_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .entry_valid         (!queue_empty),
    .entry               (queue_entry),
    .entry_take          (queue_pop),
    .session_byte_budget (session_byte_budget),
    .res_valid           (res_valid),
    .res_stall           (res_stall),
    .res                 (res)
  );

endmodule

`default_nettype wire

// ===== rtl/core/utf8pc_checker.sv =====
// Port-level checks of the page cutter and their binding to the top level.
`default_nettype none

module utf8pc_checker (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_stall,
  input utf8pc_pkg::res_t res
);
  import utf8pc_pkg::*;

  // A result held by the receiver stays in place.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A refused page delivers nothing and does not claim the end of the resource.
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != STATUS_OK |-> res.page_bytes == 17'd0 && !res.end_of_resource)
    else $error("error result carries page data");

  // An accepted page is either non-empty or marks the end of the resource.
  a_ok_content: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == STATUS_OK |-> res.page_bytes != 17'd0 || res.end_of_resource)
    else $error("ok result with empty page");

endmodule

bind utf8_page_cutter utf8pc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire
